[hdl/trb_pkg.sv]
// Shared types and constants of the timestamp reorder buffer.
package trb_pkg;

	// Widths of the event fields.
	localparam int TIME_W = 64;
	localparam int KIND_W = 4;
	localparam int PAYLOAD_W = 64;
	localparam int OPCODE_W = 2;
	localparam int COUNT_W = 6;

	// At most this many results leave the block for one input beat.
	localparam int MAX_RESULTS = 32;
	localparam int RUN_W = 6;

	// Operation codes.
	localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_FLUSH_N = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_FLUSH_ALL = 2'd2;

	// One stored event.
	typedef struct packed {
		logic [TIME_W-1:0] time_stamp;
		logic [KIND_W-1:0] event_kind;
		logic [PAYLOAD_W-1:0] payload_handle;
	} trb_entry_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic ins;
		logic pop;
		trb_entry_t ent;
	} trb_cmd_t;

endpackage

[hdl/trb_if.sv]
// Handshake channels of the timestamp reorder buffer: requests and emitted events.
interface trb_req_if;
	import trb_pkg::*;
	logic valid;
	logic ready;
	logic [OPCODE_W-1:0] opcode;
	logic [TIME_W-1:0] time_stamp;
	logic [KIND_W-1:0] event_kind;
	logic [PAYLOAD_W-1:0] payload_handle;
	logic [COUNT_W-1:0] flush_count;

	modport source (output valid, opcode, time_stamp, event_kind, payload_handle, flush_count,
		input ready);
	modport sink (input valid, opcode, time_stamp, event_kind, payload_handle, flush_count,
		output ready);
endinterface

interface trb_rsp_if;
	import trb_pkg::*;
	logic valid;
	logic ready;
	logic [TIME_W-1:0] out_time;
	logic [KIND_W-1:0] out_kind;
	logic [PAYLOAD_W-1:0] out_payload;
	logic last_of_run;

	modport source (output valid, out_time, out_kind, out_payload, last_of_run, input ready);
	modport sink (input valid, out_time, out_kind, out_payload, last_of_run, output ready);
endinterface

[hdl/trb_cell.sv]
// One cell of the sorted chain: holds one event and trades it with its neighbors.
module trb_cell
	import trb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  trb_cmd_t   cmd,
	input  trb_entry_t left_e,
	input  logic       left_v,
	input  logic       left_g,
	input  trb_entry_t right_e,
	input  logic       right_v,
	output trb_entry_t ent,
	output logic       v,
	output logic       g
);

	trb_entry_t ent_q;
	logic valid_q;

	// An empty cell, or one holding a later time, lies after the new event.
	assign g = !valid_q || (ent_q.time_stamp > cmd.ent.time_stamp);
	assign ent = ent_q;
	assign v = valid_q;

	// Occupancy follows the same moves as the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.pop) begin
			valid_q <= right_v;
		end else if (cmd.ins) begin
			if (left_g) begin
				valid_q <= left_v;
			end else if (g) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Pop shifts toward the head; insert shifts later events away from it.
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			ent_q <= right_e;
		end else if (cmd.ins) begin
			if (left_g) begin
				ent_q <= left_e;
			end else if (g) begin
				ent_q <= cmd.ent;
			end
		end
	end

endmodule

[hdl/trb_chain.sv]
// Row of cells that keeps the events sorted by time, oldest at the head.
module trb_chain
	import trb_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  trb_cmd_t   cmd,
	output trb_entry_t head
);

	trb_entry_t ents [DEPTH];
	logic [DEPTH-1:0] vs;
	logic [DEPTH-1:0] gs;

	assign head = ents[0];

	// Each cell sees its left neighbor for inserts and its right one for pops.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		trb_entry_t le;
		trb_entry_t re;
		logic lv;
		logic lg;
		logic rv;

		if (i == 0) begin : g_first
			assign le = cmd.ent;
			assign lv = 1'b0;
			assign lg = 1'b0;
		end else begin : g_mid
			assign le = ents[i-1];
			assign lv = vs[i-1];
			assign lg = gs[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign re = ents[i];
			assign rv = 1'b0;
		end else begin : g_inner
			assign re = ents[i+1];
			assign rv = vs[i+1];
		end

		trb_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.left_e  (le),
			.left_v  (lv),
			.left_g  (lg),
			.right_e (re),
			.right_v (rv),
			.ent     (ents[i]),
			.v       (vs[i]),
			.g       (gs[i])
		);
	end

endmodule

[hdl/timestamp_reorder_buffer.sv]
// Top level of the timestamp reorder buffer: control, event count and output register.
//
// Use: requests arrive on req (valid/ready). An insert beat stores an event after every
// stored event with an equal or smaller time, so equal times keep arrival order. A
// counted flush emits up to flush_count oldest events (at most 32), a full flush emits
// up to 32 of them; opcode 3 is ignored. Emitted events leave on rsp (valid/ready),
// in time order, with last_of_run set on the final event of a beat.
// Flow: an insert into a store that is not full is stored directly and the next request
// can follow at once. A flush that emits events holds req.ready low until its run is
// drained; the chain pops one event per cycle from its head into the output register
// while the receiver keeps up. An insert into a full store first emits DEPTH/2 events,
// then stores the event in a separate insert step.
// Receiver stall: while rsp.ready is low a held event stays in the output register and
// the chain stops popping; inserts are still accepted while a finished event waits.
// Reset: arst_n empties the store at once; no clearing pass is needed.
module timestamp_reorder_buffer
	import trb_pkg::*;
#(
	parameter int DEPTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	trb_req_if.sink   req,
	trb_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > RUN_W) ? CW : RUN_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DRAIN = 2'd1;
	localparam logic [1:0] ST_INSERT = 2'd2;

	logic [1:0] state_q;
	logic [CW-1:0] count_q;
	logic [RUN_W-1:0] rem_q;
	trb_entry_t pend_q;
	logic pend_q_v;
	logic out_v_q;
	trb_entry_t out_q;
	logic last_q;

	trb_cmd_t cmd;
	trb_entry_t head;
	trb_entry_t in_ent;
	logic acc;
	logic full;
	logic [RUN_W-1:0] req_n;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] req_x;
	logic [XW-1:0] run_x;

	assign acc = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign full = (count_q == CW'(DEPTH));
	assign in_ent = '{time_stamp: req.time_stamp, event_kind: req.event_kind,
		payload_handle: req.payload_handle};

	// Length of a flush run: the request, capped at the result limit and the store fill.
	always_comb begin
		if (req.opcode == OP_FLUSH_N) begin
			req_n = (req.flush_count > COUNT_W'(MAX_RESULTS)) ? RUN_W'(MAX_RESULTS)
				: RUN_W'(req.flush_count);
		end else begin
			req_n = RUN_W'(MAX_RESULTS);
		end
		cnt_x = XW'(count_q);
		req_x = XW'(req_n);
		run_x = (cnt_x < req_x) ? cnt_x : req_x;
	end

	// Commands to the chain.
	always_comb begin
		cmd.pop = (state_q == ST_DRAIN) && (!out_v_q || rsp.ready);
		cmd.ins = (acc && (req.opcode == OP_INSERT) && !full) || (state_q == ST_INSERT);
		cmd.ent = (state_q == ST_INSERT) ? pend_q : in_ent;
	end

	trb_chain #(.DEPTH(DEPTH)) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.head   (head)
	);

	// Sequencer: idle, draining a run, or storing an insert that waited for a drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rem_q <= '0;
			pend_q_v <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						case (req.opcode) inside
							OP_INSERT: begin
								if (full) begin
									state_q <= ST_DRAIN;
									rem_q <= RUN_W'(DEPTH / 2);
									pend_q_v <= 1'b1;
								end
							end
							OP_FLUSH_N, OP_FLUSH_ALL: begin
								if (run_x != '0) begin
									state_q <= ST_DRAIN;
									rem_q <= RUN_W'(run_x);
									pend_q_v <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DRAIN: begin
					if (cmd.pop) begin
						rem_q <= rem_q - RUN_W'(1);
						if (rem_q == RUN_W'(1)) begin
							state_q <= pend_q_v ? ST_INSERT : ST_IDLE;
						end
					end
				end
				ST_INSERT: begin
					state_q <= ST_IDLE;
					pend_q_v <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The insert that waits behind a drain.
	always_ff @(posedge clk) begin
		if (acc && (req.opcode == OP_INSERT)) begin
			pend_q <= in_ent;
		end
	end

	// Number of events held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.ins) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.pop) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Output register: takes the head on each pop, empties when the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.pop) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			out_q <= head;
			last_q <= (rem_q == RUN_W'(1));
		end
	end

	assign rsp.valid = out_v_q;
	assign rsp.out_time = out_q.time_stamp;
	assign rsp.out_kind = out_q.event_kind;
	assign rsp.out_payload = out_q.payload_handle;
	assign rsp.last_of_run = last_q;

endmodule

[hdl/trb_checker.sv]
// Port-level checks of the timestamp reorder buffer and their binding to the top level.
module trb_checker
	import trb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic [OPCODE_W-1:0] req_opcode,
	input logic [COUNT_W-1:0] req_flush_count,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [TIME_W-1:0] rsp_out_time,
	input logic rsp_last_of_run
);

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// A stalled result beat stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat withdrawn while stalled");

	// A stalled result beat keeps its time and marker.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_out_time) && $stable(rsp_last_of_run))
		else $error("result beat changed while stalled");

	// An unknown opcode or a counted flush of zero leaves the block ready for the next request.
	a_empty_run: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && ((req_opcode != OP_INSERT && req_opcode != OP_FLUSH_N
		&& req_opcode != OP_FLUSH_ALL) || (req_opcode == OP_FLUSH_N && req_flush_count == '0))
		|=> req_ready)
		else $error("request that emits nothing stalled the block");

	// An insert never produces a result in the following cycle.
	a_insert_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_opcode == OP_INSERT |=> !$rose(rsp_valid))
		else $error("result appeared right after an insert");

endmodule

bind timestamp_reorder_buffer trb_checker u_trb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_opcode      (req.opcode),
	.req_flush_count (req.flush_count),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_out_time    (rsp.out_time),
	.rsp_last_of_run (rsp.last_of_run)
);
